>>> rtl/uvs_pkg.sv
// Shared types, constants and the sine magnitude generator for the UV-sphere vertex generator.
// No dependencies; uv_sphere_vertex_generator imports this package, uvs_div_pipe does not.
package uvs_pkg;

    // Default parameter values for the top level.
    localparam int PHASE_BITS_DEF = 12;
    localparam int GRID_BITS_DEF  = 8;

    // 2*pi in Q30, rounded half up.
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

    // Sine magnitude is Q1.14 and never exceeds 16384.
    localparam int MAG_W = 15;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Z    = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [7:0]  COUNT_RESET  = 8'd16;
    localparam logic [15:0] RADIUS_RESET = 16'd256;

    // Grid-side information that rides alongside the divider lanes.
    typedef struct packed {
        logic        err;
        logic        last_row;
        logic [15:0] strip_upper;
        logic [15:0] strip_lower;
    } side_t;

    // Sine magnitude in Q1.14 for a phase in [0, quarter turn]. Evaluated only at
    // elaboration to fill the sine table: Q30 Taylor series through x^15.
    function automatic logic [MAG_W-1:0] sine_mag(longint unsigned ph, int unsigned pb);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned sum;
        longint unsigned term;
        longint unsigned res;
        longint unsigned prod;
        x = (ph * TWO_PI_Q30 + (64'd1 << (pb - 1))) >> pb;
        x2 = (x * x) >> 30;
        sum = x;
        term = x;
        for (int n = 1; n <= 7; n++) begin
            prod = (term * x2) >> 30;
            // Divide by (2n)(2n+1) for the current term.
            case (n)
                1:       term = prod / 64'd6;
                2:       term = prod / 64'd20;
                3:       term = prod / 64'd42;
                4:       term = prod / 64'd72;
                5:       term = prod / 64'd110;
                6:       term = prod / 64'd156;
                default: term = prod / 64'd210;
            endcase
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        res = (sum + 64'd32768) >> 16;
        if (res > 64'd16384) begin
            res = 64'd16384;
        end
        return MAG_W'(res);
    endfunction

endpackage

>>> rtl/uvs_div_pipe.sv
// Pipelined restoring divider for the UV-sphere vertex generator: one quotient bit per stage.
// Depends on nothing; the stage enable comes from the top level's stall logic.
module uvs_div_pipe #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 9
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num_i,
    input  logic [DEN_W-1:0] den_i,
    output logic [NUM_W-1:0] quo_o
);

    // Per-stage partial remainder, shifting dividend/quotient word and divisor.
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [DEN_W-1:0] rem_prev;
        logic [NUM_W-1:0] num_prev;
        logic [DEN_W-1:0] den_prev;
        logic [DEN_W:0]   trial;
        logic             fits;
        logic [DEN_W-1:0] rem_next;
        logic [NUM_W-1:0] num_next;

        if (s == 0) begin : g_first
            assign rem_prev = '0;
            assign num_prev = num_i;
            assign den_prev = den_i;
        end else begin : g_rest
            assign rem_prev = rem_reg[s-1];
            assign num_prev = num_reg[s-1];
            assign den_prev = den_reg[s-1];
        end

        // Bring down the next dividend bit and try one subtraction.
        assign trial    = {rem_prev, num_prev[NUM_W-1]};
        assign fits     = (trial >= {1'b0, den_prev});
        assign rem_next = fits ? DEN_W'(trial - {1'b0, den_prev}) : DEN_W'(trial);
        assign num_next = {num_prev[NUM_W-2:0], fits};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= rem_next;
                num_reg[s] <= num_next;
                den_reg[s] <= den_prev;
            end
        end
    end

    assign quo_o = num_reg[NUM_W-1];

endmodule

>>> rtl/uv_sphere_vertex_generator.sv
// Top level of the UV-sphere vertex generator: config registers, dividers, sine table, products.
// Depends on uvs_pkg and uvs_div_pipe.
//
//   Channel  Direction  Handshake            Payload
//   s_       in         s_valid / s_ready    stack_index, slice_index
//   m_       out        m_valid / m_ready    normals, positions, tex coords, strip pair, error
//   cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One grid point enters per cycle while the pipeline advances; a beat taken passes through
// NUM_W + 6 register stages before it shows on m_, NUM_W being the
// divider length GRID_BITS + max(PHASE_BITS, 16) + 1 (one quotient bit per stage).
// Synchronous active-low reset clears valid bits and loads the register defaults.
// The whole pipeline advances together whenever the output register is empty or taken,
// so a stall freezes every stage and no beat is lost or repeated.
module uv_sphere_vertex_generator
    import uvs_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF,
    parameter int GRID_BITS  = GRID_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_stack_index,
    input  logic [7:0]           s_slice_index,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [15:0]   m_normal_x,
    output logic signed [15:0]   m_normal_y,
    output logic signed [15:0]   m_normal_z,
    output logic signed [16:0]   m_pos_x,
    output logic signed [16:0]   m_pos_y,
    output logic signed [16:0]   m_pos_z,
    output logic [16:0]          m_tex_u,
    output logic [16:0]          m_tex_v,
    output logic [15:0]          m_strip_upper,
    output logic [15:0]          m_strip_lower,
    output logic                 m_strip_valid,
    output logic                 m_grid_error,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    localparam int G       = GRID_BITS;
    localparam int PB      = PHASE_BITS;
    localparam int NUM_W   = G + ((PB > 16) ? PB : 16) + 1;
    localparam int DEN_W   = G + 1;
    localparam int QUARTER = 1 << (PB - 2);
    localparam int ROM_AW  = PB - 1;
    localparam int POST_N  = 5;

    typedef logic [MAG_W-1:0] sine_rom_t [0:QUARTER];

    typedef struct packed {
        side_t       side;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
    } post_t;

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t r;
        for (int i = 0; i <= QUARTER; i++) begin
            r[i] = sine_mag(longint'(i), PB);
        end
        return r;
    endfunction

    // Two copies of the table so that each is read at two addresses per cycle.
    localparam sine_rom_t SINE_ROM_A = build_sine_rom();
    localparam sine_rom_t SINE_ROM_B = build_sine_rom();

    // Quadrant fold: MSB of the result is the sign, the rest the table address.
    function automatic logic [PB-1:0] fold_phase(logic [PB-1:0] k);
        logic [ROM_AW-1:0] r;
        logic [ROM_AW-1:0] a;
        r = ROM_AW'(k[PB-3:0]);
        a = k[PB-2] ? (ROM_AW'(QUARTER) - r) : r;
        return {k[PB-1], a};
    endfunction

    logic adv;

    // Configuration registers.
    logic [7:0]  stack_count_reg;
    logic [7:0]  slice_count_reg;
    logic [15:0] radius_x_reg;
    logic [15:0] radius_y_reg;
    logic [15:0] radius_z_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_count_reg <= COUNT_RESET;
            slice_count_reg <= COUNT_RESET;
            radius_x_reg    <= RADIUS_RESET;
            radius_y_reg    <= RADIUS_RESET;
            radius_z_reg    <= RADIUS_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_STACK_COUNT: stack_count_reg <= cfg_data[7:0];
                CFG_SLICE_COUNT: slice_count_reg <= cfg_data[7:0];
                CFG_RADIUS_X:    radius_x_reg    <= cfg_data;
                CFG_RADIUS_Y:    radius_y_reg    <= cfg_data;
                CFG_RADIUS_Z:    radius_z_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Input decode: grid checks, strip indices and divider operands.
    logic [G-1:0]     stacks;
    logic [G-1:0]     slices;
    logic [G-1:0]     st;
    logic [G-1:0]     sl;
    logic             in_err;
    logic [2*G:0]     upper_full;
    logic [2*G+1:0]   lower_full;
    side_t            in_side;
    logic [NUM_W-1:0] num_theta;
    logic [NUM_W-1:0] num_phi;
    logic [NUM_W-1:0] num_u;
    logic [NUM_W-1:0] num_v;
    logic [G-1:0]     v_diff;

    assign stacks = stack_count_reg[G-1:0];
    assign slices = slice_count_reg[G-1:0];
    assign st     = s_stack_index[G-1:0];
    assign sl     = s_slice_index[G-1:0];
    assign in_err = (stacks == '0) || (slices == '0) || (st > stacks) || (sl > slices);

    assign upper_full = (2*G+1)'(st) * ((2*G+1)'(slices) + (2*G+1)'(1)) + (2*G+1)'(sl);
    assign lower_full = (2*G+2)'(upper_full) + (2*G+2)'({1'b0, slices}) + 1'b1;

    assign in_side.err         = in_err;
    assign in_side.last_row    = (st == stacks);
    assign in_side.strip_upper = 16'(upper_full);
    assign in_side.strip_lower = 16'(lower_full);

    assign v_diff    = stacks - st;
    assign num_theta = NUM_W'({st, {PB{1'b0}}}) + NUM_W'(stacks);
    assign num_phi   = NUM_W'({sl, {(PB + 1){1'b0}}}) + NUM_W'(slices);
    assign num_u     = NUM_W'({sl, 16'd0});
    assign num_v     = NUM_W'({v_diff, 16'd0});

    // Four divider lanes: theta, phi and both texture coordinates.
    logic [NUM_W-1:0] quo_theta;
    logic [NUM_W-1:0] quo_phi;
    logic [NUM_W-1:0] quo_u;
    logic [NUM_W-1:0] quo_v;

    uvs_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_theta (
        .aclk(aclk), .en(adv), .num_i(num_theta), .den_i({stacks, 1'b0}), .quo_o(quo_theta)
    );
    uvs_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_phi (
        .aclk(aclk), .en(adv), .num_i(num_phi), .den_i({slices, 1'b0}), .quo_o(quo_phi)
    );
    uvs_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_u (
        .aclk(aclk), .en(adv), .num_i(num_u), .den_i({1'b0, slices}), .quo_o(quo_u)
    );
    uvs_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_v (
        .aclk(aclk), .en(adv), .num_i(num_v), .den_i({1'b0, stacks}), .quo_o(quo_v)
    );

    // Side line that keeps valid bits and grid data level with the divider stages.
    logic  vld_reg  [NUM_W];
    side_t side_reg [NUM_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_W; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < NUM_W; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= in_side;
            for (int i = 1; i < NUM_W; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Post-divider control: valid bits and carried payload.
    logic  pv_reg   [POST_N];
    post_t post_reg [POST_N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < POST_N; i++) begin
                pv_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            pv_reg[0] <= vld_reg[NUM_W-1];
            for (int i = 1; i < POST_N; i++) begin
                pv_reg[i] <= pv_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            post_reg[0].side  <= side_reg[NUM_W-1];
            post_reg[0].tex_u <= quo_u[16:0];
            post_reg[0].tex_v <= quo_v[16:0];
            for (int i = 1; i < POST_N; i++) begin
                post_reg[i] <= post_reg[i-1];
            end
        end
    end

    // Stage 0: phases, quadrant fold and table read.
    logic [PB-1:0] theta;
    logic [PB-1:0] phi;
    logic [PB-1:0] fold_st;
    logic [PB-1:0] fold_ct;
    logic [PB-1:0] fold_sp;
    logic [PB-1:0] fold_cp;
    logic [MAG_W-1:0] mag_reg [4];
    logic             neg_reg [4];

    assign theta   = quo_theta[PB-1:0];
    assign phi     = quo_phi[PB-1:0] + PB'(QUARTER);
    assign fold_st = fold_phase(theta);
    assign fold_ct = fold_phase(theta + PB'(QUARTER));
    assign fold_sp = fold_phase(phi);
    assign fold_cp = fold_phase(phi + PB'(QUARTER));

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag_reg[0] <= SINE_ROM_A[fold_st[ROM_AW-1:0]];
            mag_reg[1] <= SINE_ROM_A[fold_ct[ROM_AW-1:0]];
            mag_reg[2] <= SINE_ROM_B[fold_sp[ROM_AW-1:0]];
            mag_reg[3] <= SINE_ROM_B[fold_cp[ROM_AW-1:0]];
            neg_reg[0] <= fold_st[PB-1];
            neg_reg[1] <= fold_ct[PB-1];
            neg_reg[2] <= fold_sp[PB-1];
            neg_reg[3] <= fold_cp[PB-1];
        end
    end

    // Stage 1: apply the quadrant sign.
    logic signed [15:0] trig_reg [4];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                trig_reg[i] <= neg_reg[i] ? -$signed({1'b0, mag_reg[i]})
                                          : $signed({1'b0, mag_reg[i]});
            end
        end
    end

    // Stage 2: longitude times latitude products.
    logic signed [31:0] prod_x_reg;
    logic signed [31:0] prod_y_reg;
    logic signed [15:0] nz2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_x_reg <= trig_reg[3] * trig_reg[0];
            prod_y_reg <= trig_reg[2] * trig_reg[0];
            nz2_reg    <= trig_reg[1];
        end
    end

    // Stage 3: round the products back to Q1.14.
    logic signed [31:0] rnd_x;
    logic signed [31:0] rnd_y;
    logic signed [15:0] nx_reg;
    logic signed [15:0] ny_reg;
    logic signed [15:0] nz3_reg;

    assign rnd_x = (prod_x_reg + 32'sd8192) >>> 14;
    assign rnd_y = (prod_y_reg + 32'sd8192) >>> 14;

    always_ff @(posedge aclk) begin
        if (adv) begin
            nx_reg  <= 16'(rnd_x);
            ny_reg  <= 16'(rnd_y);
            nz3_reg <= nz2_reg;
        end
    end

    // Stage 4: scale by the per-axis radius.
    logic signed [32:0] rp_x_reg;
    logic signed [32:0] rp_y_reg;
    logic signed [32:0] rp_z_reg;
    logic signed [15:0] nx4_reg;
    logic signed [15:0] ny4_reg;
    logic signed [15:0] nz4_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            rp_x_reg <= $signed({1'b0, radius_x_reg}) * nx_reg;
            rp_y_reg <= $signed({1'b0, radius_y_reg}) * ny_reg;
            rp_z_reg <= $signed({1'b0, radius_z_reg}) * nz3_reg;
            nx4_reg  <= nx_reg;
            ny4_reg  <= ny_reg;
            nz4_reg  <= nz3_reg;
        end
    end

    // Output register: round positions and clear fields on grid errors.
    logic signed [32:0] pos_x_rnd;
    logic signed [32:0] pos_y_rnd;
    logic signed [32:0] pos_z_rnd;
    post_t              fin;
    logic               m_valid_reg;

    assign pos_x_rnd = (rp_x_reg + 33'sd8192) >>> 14;
    assign pos_y_rnd = (rp_y_reg + 33'sd8192) >>> 14;
    assign pos_z_rnd = (rp_z_reg + 33'sd8192) >>> 14;
    assign fin       = post_reg[POST_N-1];

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= pv_reg[POST_N-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_grid_error <= fin.side.err;
            if (fin.side.err) begin
                m_normal_x    <= '0;
                m_normal_y    <= '0;
                m_normal_z    <= '0;
                m_pos_x       <= '0;
                m_pos_y       <= '0;
                m_pos_z       <= '0;
                m_tex_u       <= '0;
                m_tex_v       <= '0;
                m_strip_upper <= '0;
                m_strip_lower <= '0;
                m_strip_valid <= 1'b0;
            end else begin
                m_normal_x    <= nx4_reg;
                m_normal_y    <= ny4_reg;
                m_normal_z    <= nz4_reg;
                m_pos_x       <= 17'(pos_x_rnd);
                m_pos_y       <= 17'(pos_y_rnd);
                m_pos_z       <= 17'(pos_z_rnd);
                m_tex_u       <= fin.tex_u;
                m_tex_v       <= fin.tex_v;
                m_strip_upper <= fin.side.strip_upper;
                m_strip_lower <= fin.side.last_row ? 16'd0 : fin.side.strip_lower;
                m_strip_valid <= !fin.side.last_row;
            end
        end
    end

    // A flagged grid point carries no geometry and no strip pair.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_grid_error |-> !m_strip_valid && m_pos_x == 17'sd0 && m_tex_u == 17'd0)
        else $error("grid error beat carries data");

    // Within one strip the lower index sits one row below the upper one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_strip_valid && !cfg_valid |->
        m_strip_lower == 16'(m_strip_upper + 16'(slices) + 16'd1))
        else $error("strip pair out of step");

    // The x and z normal components stay within the unit range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_normal_z <= 16'sd16384 && m_normal_z >= -16'sd16384
                 && m_normal_x <= 16'sd16384 && m_normal_x >= -16'sd16384)
        else $error("normal out of range");

endmodule
